>>> rtl/core/aescbc_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CBC decrypt package
// Shared types, the round-key ROM and the inverse round function.
// ----------------------------------------------------------------------------
`default_nettype none

package aescbc_pkg;

  localparam int unsigned KEY_COUNT = 11;
  localparam int unsigned REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_IV_HIGH = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_IV_LOW  = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;      // take the input word and add the last round key
    logic       round;     // run one inverse round
    logic       last;      // this round omits inverse mix columns
    logic [3:0] key_sel;   // round key used by this step
    logic       finish;    // xor with chain, load output, update chain
  } dp_cmd_t;

  function automatic logic [127:0] round_key(input logic [3:0] idx);
    logic [127:0] k;
    begin
      case (idx)
        4'd0:  k = 128'h01020304050607080900000000000000;
        4'd1:  k = 128'h636160676667676F6F67676F6F67676F;
        4'd2:  k = 128'hE4E4C8CF8283AFA0EDE4C8CF8283AFA0;
        4'd3:  k = 128'h0C9D28DC8E1E877C63FA4FB3E179E013;
        4'd4:  k = 128'hB27C55243C62D2585F989DEBBEE17DF8;
        4'd5:  k = 128'h5A83148A66E1C6D239795B39879826C1;
        4'd6:  k = 128'h3C746C9D5A95AA4F63ECF176E474D7B7;
        4'd7:  k = 128'hEE7AC5F4B4EF6FBBD7039ECD3377497A;
        4'd8:  k = 128'h9B411F372FAE708CF8ADEE41CBDAA73B;
        4'd9:  k = 128'hD71DFD28F8B38DA4001E63E5CBC4C4DE;
        4'd10: k = 128'hFD01E03705B26D9305AC0E76CE68CAA8;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    begin
      t = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
      };
      return t[a];
    end
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by 9, 11, 13 and 14 share the same doublings.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    begin
      for (int i = 0; i < 4; i++) begin
        a[i]   = c[31-8*i -: 8];
        x2[i]  = xtime(a[i]);
        x4[i]  = xtime(x2[i]);
        x8[i]  = xtime(x4[i]);
        m9[i]  = x8[i] ^ a[i];
        m11[i] = x8[i] ^ x2[i] ^ a[i];
        m13[i] = x8[i] ^ x4[i] ^ a[i];
        m14[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    end
  endfunction

  // State byte i sits at bits 127-8i; byte index is row + 4*column.
  function automatic logic [127:0] inv_round(input logic [127:0] s,
                                             input logic [127:0] key,
                                             input logic skip_mix);
    logic [127:0] t;
    logic [127:0] m;
    begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          t[127-8*(r+4*c) -: 8] = inv_sbox(s[127-8*(r+4*((c+4-r)%4)) -: 8]);
        end
      end
      t = t ^ key;
      for (int c = 0; c < 4; c++) begin
        m[127-32*c -: 32] = inv_mix_col(t[127-32*c -: 32]);
      end
      return skip_mix ? t : m;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/aescbc_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 CBC decrypt controller
// Sequences the key add, ten inverse rounds and the output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module aescbc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      aescbc_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [3:0] rnd;
  logic [3:0] rnd_next;
  logic       out_valid_next;
  logic       accept;

  // A new word is taken while idle; the output register holds the old result
  // until the finish step needs it.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load    = 1'b1;
          cmd.key_sel = 4'(aescbc_pkg::KEY_COUNT - 1);
          rnd_next    = 4'(aescbc_pkg::KEY_COUNT - 2);
          state_next  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round   = 1'b1;
        cmd.key_sel = rnd;
        cmd.last    = (rnd == 4'd0);
        rnd_next    = rnd - 4'd1;
        if (rnd == 4'd0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aescbc_dp.sv
// ----------------------------------------------------------------------------
// AES-128 CBC decrypt datapath
// State register, shared inverse round, chain and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module aescbc_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire aescbc_pkg::dp_cmd_t  cmd,
  input  wire logic [63:0]          cipher_high,
  input  wire logic [63:0]          cipher_low,
  input  wire logic                 start_of_message,
  input  wire logic [63:0]          iv_high,
  input  wire logic [63:0]          iv_low,
  output      logic [63:0]          plain_high,
  output      logic [63:0]          plain_low
);

  logic [127:0] st;
  logic [127:0] cipher;
  logic [127:0] chain;
  logic         sop;
  logic [127:0] key;
  logic [127:0] chain_sel;

  assign key       = aescbc_pkg::round_key(cmd.key_sel);
  assign chain_sel = sop ? {iv_high, iv_low} : chain;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st     <= {cipher_high, cipher_low} ^ key;
      cipher <= {cipher_high, cipher_low};
      sop    <= start_of_message;
    end else if (cmd.round) begin
      st <= aescbc_pkg::inv_round(st, key, cmd.last);
    end
    if (cmd.finish) begin
      {plain_high, plain_low} <= st ^ chain_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.finish) begin
      chain <= cipher;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/aes128_cbc_block_decrypt.sv
// ----------------------------------------------------------------------------
// AES-128 CBC block decrypt
// Fixed-key AES-128 inverse cipher with CBC chaining, one round per cycle.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Word
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | cipher_high, cipher_low, start_of_message
//  output   | out_valid/ out_stall | plain_high, plain_low
//  config   | cfg_we               | cfg_index, cfg_data (iv_high, iv_low)
//
// The edge that accepts a word loads it into the state register and adds the
// last round key. The ten inverse rounds then run through the shared round
// unit, and a final step applies the chain xor and loads the output register
// once it is free. A new word is accepted only after that finish step, when
// the block is idle again, so words are not overlapped.
// Reset clears the IV registers, the chain block and all control state.
// A stalled result holds the last step; the input is not stalled by it until
// then.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_cbc_block_decrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [aescbc_pkg::REG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [63:0] cipher_high,
  input  wire logic [63:0] cipher_low,
  input  wire logic        start_of_message,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] plain_high,
  output      logic [63:0] plain_low
);

  aescbc_pkg::dp_cmd_t cmd;
  logic [63:0] iv_high;
  logic [63:0] iv_low;

  // IV registers. The index is one bit wide, so every write hits a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_high <= '0;
      iv_low  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        aescbc_pkg::REG_IV_HIGH: iv_high <= cfg_data;
        aescbc_pkg::REG_IV_LOW:  iv_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aescbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  aescbc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cipher_high      (cipher_high),
    .cipher_low       (cipher_low),
    .start_of_message (start_of_message),
    .iv_high          (iv_high),
    .iv_low           (iv_low),
    .plain_high       (plain_high),
    .plain_low        (plain_low)
  );

`ifndef ASSERT_OFF
  // Only one datapath command is issued in any cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.round, cmd.finish}))
    else $error("datapath commands overlap");

  // An accepted word starts the round sequence on the next cycle.
  a_load_then_round: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.round)
    else $error("load not followed by a round");

  // The output register is only reloaded when it is free.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> test/tb_aes128_cbc_block_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC block decrypt testbench
// Sends ciphertext words through the block under changing IV settings and
// idle patterns, predicts each plaintext with an independent inverse cipher
// and CBC chain, and compares every output word in order.
// ----------------------------------------------------------------------------

module tb_aes128_cbc_block_decrypt;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } plain_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [aescbc_pkg::REG_INDEX_W-1:0] cfg_index = aescbc_pkg::REG_IV_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] cipher_high = '0;
  logic [63:0] cipher_low = '0;
  logic        start_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] plain_high;
  logic [63:0] plain_low;

  // Predictor state: IV registers and the previous ciphertext block.
  logic [63:0] iv_hi_m = '0, iv_lo_m = '0;
  logic [63:0] prev_hi = '0, prev_lo = '0;
  plain_t      plain_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  longint unsigned cycle_count = 0;

  aes128_cbc_block_decrypt u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Key table and inverse S-box, kept separately from the package.
  logic [7:0] sbox_inv [256];
  logic [7:0] key_rom [176];
  initial begin
    logic [127:0] rows [11];
    logic [7:0] fwd [256];
    logic [7:0] p, q, x;
    rows = '{128'h01020304050607080900000000000000,
             128'h636160676667676F6F67676F6F67676F,
             128'hE4E4C8CF8283AFA0EDE4C8CF8283AFA0,
             128'h0C9D28DC8E1E877C63FA4FB3E179E013,
             128'hB27C55243C62D2585F989DEBBEE17DF8,
             128'h5A83148A66E1C6D239795B39879826C1,
             128'h3C746C9D5A95AA4F63ECF176E474D7B7,
             128'hEE7AC5F4B4EF6FBBD7039ECD3377497A,
             128'h9B411F372FAE708CF8ADEE41CBDAA73B,
             128'hD71DFD28F8B38DA4001E63E5CBC4C4DE,
             128'hFD01E03705B26D9305AC0E76CE68CAA8};
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++)
        key_rom[16*r+i] = rows[r][127-8*i -: 8];
    // Build the forward S-box from the field inverse and affine map, then
    // invert it, so the prediction does not reuse any listed table.
    p = 8'h01;
    q = 8'h01;
    fwd[0] = 8'h63;
    do begin
      p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      q = q ^ {q[6:0], 1'b0};
      q = q ^ {q[5:0], 2'b0};
      q = q ^ {q[3:0], 4'b0};
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
          ^ {q[3:0], q[7:4]} ^ 8'h63;
      fwd[p] = x;
    end while (p != 8'h01);
    for (int i = 0; i < 256; i++) sbox_inv[fwd[i]] = i[7:0];
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input int unsigned b);
    logic [7:0] acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b >>= 1;
    end
    return acc;
  endfunction

  // Full inverse cipher plus CBC xor; updates the chain as the block does.
  function automatic plain_t decrypt_word(input logic [63:0] c_hi,
                                          input logic [63:0] c_lo,
                                          input logic sof);
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    plain_t res;
    for (int i = 0; i < 8; i++) begin
      st[i] = c_hi[63-8*i -: 8];
      st[8+i] = c_lo[63-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) st[i] ^= key_rom[160+i];
    for (int rnd = 9; rnd >= 0; rnd--) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r+4*c] = sbox_inv[st[r+4*((c+4-r)%4)]];
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ key_rom[16*rnd+i];
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gmul(a0,14) ^ gmul(a1,11) ^ gmul(a2,13) ^ gmul(a3,9);
          st[4*c+1] = gmul(a0,9) ^ gmul(a1,14) ^ gmul(a2,11) ^ gmul(a3,13);
          st[4*c+2] = gmul(a0,13) ^ gmul(a1,9) ^ gmul(a2,14) ^ gmul(a3,11);
          st[4*c+3] = gmul(a0,11) ^ gmul(a1,13) ^ gmul(a2,9) ^ gmul(a3,14);
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    res.hi ^= sof ? iv_hi_m : prev_hi;
    res.lo ^= sof ? iv_lo_m : prev_lo;
    prev_hi = c_hi;
    prev_lo = c_lo;
    return res;
  endfunction

  // Sends one ciphertext word, with a random idle gap first, and queues
  // its plaintext once the block accepts it.
  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                           input logic sof);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    cipher_high = hi;
    cipher_low = lo;
    start_of_message = sof;
    do @(posedge clk); while (in_stall);
    plain_q.push_back(decrypt_word(hi, lo, sof));
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every queued plaintext has come out, plus a margin so the
  // block is fully idle.
  task automatic drain();
    while (plain_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [aescbc_pkg::REG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == aescbc_pkg::REG_IV_HIGH) iv_hi_m = val;
    else iv_lo_m = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: random stalls driven at the falling edge.
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Output checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    plain_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (plain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h %h", plain_high, plain_low);
      end else begin
        exp_w = plain_q.pop_front();
        words_checked++;
        if (plain_high !== exp_w.hi || plain_low !== exp_w.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plaintext mismatch: expected %h %h, got %h %h",
                     exp_w.hi, exp_w.lo, plain_high, plain_low);
        end
      end
    end
  end

  // Watchdog, far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Directed: chain before any block is all zeros, field extremes, both
  // start flag values, and IV extremes.
  task automatic test_directed();
    send_word('0, '0, 1'b0);
    send_word('1, '1, 1'b0);
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    send_word(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    send_word(64'h0000000000000001, 64'h8000000000000000, 1'b1);
    drain();
    write_reg(aescbc_pkg::REG_IV_HIGH, '1);
    write_reg(aescbc_pkg::REG_IV_LOW, '1);
    send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
    send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
    send_word('0, '1, 1'b1);
    drain();
    write_reg(aescbc_pkg::REG_IV_HIGH, 64'h0001020304050607);
    write_reg(aescbc_pkg::REG_IV_LOW, 64'h08090a0b0c0d0e0f);
    send_word('1, '0, 1'b1);
    send_word(rand64(), rand64(), 1'b0);
    // Hold the input back until the pipeline has emptied, then resume.
    drain();
    send_word(rand64(), rand64(), 1'b0);
    drain();
  endtask

  // Random messages: a start word followed by a run of one to twelve words, mostly
  // chained but with a random start flag on some, and the IV changed before each message.
  task automatic test_random_messages(input int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) begin
      drain();
      write_reg(aescbc_pkg::REG_IV_HIGH, rand64());
      write_reg(aescbc_pkg::REG_IV_LOW, rand64());
      send_word(rand64(), rand64(), 1'b1);
      n++;
      repeat ($urandom_range(1, 12)) begin
        send_word(rand64(), rand64(), $urandom_range(9) == 0);
        n++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_directed();
    send_idle_pct = 15;
    recv_idle_pct = 67;
    test_random_messages(170);
    send_idle_pct = 67;
    recv_idle_pct = 15;
    test_random_messages(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(170);
    write_reg(aescbc_pkg::REG_IV_HIGH, '0);
    write_reg(aescbc_pkg::REG_IV_LOW, '0);
    drain();
    $display("Decrypted %0d words (%0d checked) across directed and random CBC messages,",
             words_sent, words_checked);
    $display("with IV extremes and three sender/receiver idle mixes.");
    if (mismatches == 0 && plain_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/aescbc_pkg.sv
rtl/core/aescbc_ctrl.sv
rtl/core/aescbc_dp.sv
rtl/core/aes128_cbc_block_decrypt.sv
test/tb_aes128_cbc_block_decrypt.sv
